>>> design/psg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psg_pkg;

	localparam int PIPE_DEPTH = 9;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 2;
	localparam int QUOT_W = 12;
	localparam int RECIP_SHIFT = 52;

	localparam logic [31:0] LCG_MUL = 32'd1664525;
	localparam logic [31:0] LCG_ADD = 32'd1013904223;
	localparam logic [31:0] PAT_X_MUL = 32'd1717986918;
	localparam logic [31:0] PAT_Y_MUL = 32'd858993459;
	localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / 64'(LCG_MUL));

	typedef enum logic [1:0] {
		MODE_UNIFORM = 2'd0,
		MODE_MORTON  = 2'd1,
		MODE_SOBOL   = 2'd2,
		MODE_LINEAR  = 2'd3
	} seed_mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SEED_MODE   = 2'd0,
		REG_EXTRA_STEPS = 2'd1
	} reg_index_t;

	function automatic logic [31:0] lcg_next(input logic [31:0] s);
		lcg_next = LCG_MUL * s + LCG_ADD;
	endfunction

	function automatic logic [31:0] rev32(input logic [31:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = v[31-i];
		end
		rev32 = r;
	endfunction

	function automatic logic [15:0] rev16(input logic [15:0] v);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[i] = v[15-i];
		end
		rev16 = r;
	endfunction

	function automatic logic [31:0] spread16(input logic [15:0] v);
		logic [31:0] r;
		for (int i = 0; i < 16; i++) begin
			r[2*i]   = v[i];
			r[2*i+1] = 1'b0;
		end
		spread16 = r;
	endfunction

	function automatic logic [31:0] fold16(input logic [31:0] e);
		fold16 = e ^ (e >> 16);
	endfunction

endpackage

`default_nettype wire

>>> design/psg_lcg_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module psg_lcg_stage (
	input  wire logic        clk,
	input  wire logic        load,
	input  wire logic        advance,
	input  wire logic [31:0] cur_seed,
	output logic      [31:0] next_seed
);

	logic [31:0] stepped;

	assign stepped = psg_pkg::lcg_next(cur_seed);

	always_ff @(posedge clk) begin
		if (load) begin
			next_seed <= advance ? stepped : cur_seed;
		end
	end

endmodule

`default_nettype wire

>>> design/pixel_seed_generator.sv
// Throughput: one request per cycle; each of the nine stages holds only
// while its successor is full and stalled, so bubbles are squeezed out.
// Reset: all stage valid bits clear, seed_mode returns to morton (1)
// and extra_steps to 0; the configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module pixel_seed_generator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic [15:0]                       pixel_x,
	input  wire logic [15:0]                       pixel_y,
	input  wire logic [15:0]                       sample_index,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output logic      [31:0]                       seed,
	output logic      [31:0]                       lcg_value,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [psg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [psg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	psg_pkg::seed_mode_t seed_mode_q;
	logic [1:0]          extra_steps_q;

	logic [psg_pkg::PIPE_DEPTH:1]   vld_q;
	logic [psg_pkg::PIPE_DEPTH+1:1] rdy;

	// stage 1
	logic [31:0] x_spread, y_spread, e_xy, e_y, smp_rev, smp_mul, seed_pre;
	psg_pkg::seed_mode_t mode_s1, mode_s2, mode_s3, mode_s4;
	logic [1:0]  steps_s1, steps_s2, steps_s3, steps_s4, steps_s5, steps_s6, steps_s7;
	logic [31:0] seed_s1, seed_s2, seed_s3, seed_s4, seed_s5;
	logic [15:0] rev_s1, rev_s2, rev_s3, rev_s4;
	logic [31:0] px_s1, py_s1;
	// stages 2 to 5: linear pattern divide
	logic [31:0] n_s2, n_s3;
	logic [63:0] recip_prod;
	logic [psg_pkg::QUOT_W-1:0] q_s3, q_s4, q_fix;
	logic [31:0] r_s4, qd;
	logic [31:0] seed_s6, seed_s7, seed_s8, seed_s9, lcg_s9;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_mode_q   <= psg_pkg::MODE_MORTON;
			extra_steps_q <= 2'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				psg_pkg::REG_SEED_MODE:   seed_mode_q   <= psg_pkg::seed_mode_t'(cfg_data);
				psg_pkg::REG_EXTRA_STEPS: extra_steps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage takes new data when empty or when its successor moves
	always_comb begin
		rdy[psg_pkg::PIPE_DEPTH+1] = !res_stall;
		for (int k = psg_pkg::PIPE_DEPTH; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign req_stall = !rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= req_valid;
			end
			for (int k = 2; k <= psg_pkg::PIPE_DEPTH; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign x_spread = psg_pkg::spread16(pixel_x);
	assign y_spread = psg_pkg::spread16(pixel_y);
	assign e_xy     = psg_pkg::rev32(y_spread | (x_spread << 1));
	assign e_y      = psg_pkg::rev32(y_spread);
	assign smp_rev  = {psg_pkg::rev16(sample_index), 16'h0000};
	assign smp_mul  = psg_pkg::LCG_ADD * {16'h0000, sample_index};

	// the sobol term of pixel_x lives only above bit 15 and drops out of the mask
	always_comb begin
		case (seed_mode_q)
			psg_pkg::MODE_UNIFORM: seed_pre = smp_rev;
			psg_pkg::MODE_MORTON:  seed_pre = psg_pkg::fold16(e_xy) ^ smp_mul;
			psg_pkg::MODE_SOBOL:   seed_pre = psg_pkg::fold16(e_y) + smp_rev;
			default:               seed_pre = 32'h0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			mode_s1  <= seed_mode_q;
			steps_s1 <= extra_steps_q;
			seed_s1  <= seed_pre;
			rev_s1   <= psg_pkg::rev16(sample_index);
			px_s1    <= {16'h0000, pixel_x} * psg_pkg::PAT_X_MUL;
			py_s1    <= {16'h0000, pixel_y} * psg_pkg::PAT_Y_MUL;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			mode_s2  <= mode_s1;
			steps_s2 <= steps_s1;
			seed_s2  <= seed_s1;
			rev_s2   <= rev_s1;
			n_s2     <= px_s1 + py_s1 - psg_pkg::LCG_ADD;
		end
	end

	assign recip_prod = 64'(n_s2) * 64'(psg_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			mode_s3  <= mode_s2;
			steps_s3 <= steps_s2;
			seed_s3  <= seed_s2;
			rev_s3   <= rev_s2;
			n_s3     <= n_s2;
			q_s3     <= recip_prod[psg_pkg::RECIP_SHIFT +: psg_pkg::QUOT_W];
		end
	end

	assign qd = {{(32-psg_pkg::QUOT_W){1'b0}}, q_s3} * psg_pkg::LCG_MUL;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			mode_s4  <= mode_s3;
			steps_s4 <= steps_s3;
			seed_s4  <= seed_s3;
			rev_s4   <= rev_s3;
			q_s4     <= q_s3;
			r_s4     <= n_s3 - qd;
		end
	end

	// estimate is at most one low
	assign q_fix = q_s4 + psg_pkg::QUOT_W'(r_s4 >= psg_pkg::LCG_MUL);

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			steps_s5 <= steps_s4;
			if (mode_s4 == psg_pkg::MODE_LINEAR) begin
				seed_s5 <= {{(32-psg_pkg::QUOT_W){1'b0}}, q_fix} ^ {rev_s4, 16'h0000};
			end else begin
				seed_s5 <= seed_s4;
			end
		end
	end

	psg_lcg_stage u_adv1 (
		.clk       (clk),
		.load      (rdy[6]),
		.advance   (steps_s5 > 2'd0),
		.cur_seed  (seed_s5),
		.next_seed (seed_s6)
	);

	psg_lcg_stage u_adv2 (
		.clk       (clk),
		.load      (rdy[7]),
		.advance   (steps_s6 > 2'd1),
		.cur_seed  (seed_s6),
		.next_seed (seed_s7)
	);

	psg_lcg_stage u_adv3 (
		.clk       (clk),
		.load      (rdy[8]),
		.advance   (steps_s7 > 2'd2),
		.cur_seed  (seed_s7),
		.next_seed (seed_s8)
	);

	psg_lcg_stage u_value (
		.clk       (clk),
		.load      (rdy[9]),
		.advance   (1'b1),
		.cur_seed  (seed_s8),
		.next_seed (lcg_s9)
	);

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			steps_s6 <= steps_s5;
		end
		if (rdy[7]) begin
			steps_s7 <= steps_s6;
		end
		if (rdy[9]) begin
			seed_s9 <= seed_s8;
		end
	end

	assign res_valid = vld_q[psg_pkg::PIPE_DEPTH];
	assign seed      = seed_s9;
	assign lcg_value = lcg_s9;

endmodule

`default_nettype wire
